/* hdl/mtep_pkg.sv */
package mtep_pkg;

  localparam int CHANNEL_COUNT = 16;
  localparam int NOTE_COUNT    = 128;
  localparam int CH_W          = $clog2(CHANNEL_COUNT);
  localparam int NOTE_W        = $clog2(NOTE_COUNT);
  localparam int ADDR_W        = CH_W + NOTE_W;

  localparam int IN_TDATA_W  = 24;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 96;
  localparam int OUT_TUSER_W = 3;

  // Status and meta codes
  localparam logic [3:0] HI_NOTE_OFF = 4'h8;
  localparam logic [3:0] HI_NOTE_ON  = 4'h9;
  localparam logic [3:0] HI_PROGRAM  = 4'hC;
  localparam logic [3:0] HI_PRESSURE = 4'hD;
  localparam logic [3:0] HI_BEND     = 4'hE;
  localparam logic [3:0] HI_SYSTEM   = 4'hF;
  localparam logic [7:0] STATUS_META = 8'hFF;
  localparam logic [7:0] META_EOT    = 8'h2F;
  localparam logic [7:0] META_TEMPO  = 8'h51;

  localparam logic [7:0]  VEL_OFF     = 8'hFF;
  localparam logic [13:0] BEND_CENTER = 14'h2000;
  localparam logic [1:0]  TEMPO_LAST  = 2'd2;
  localparam logic [1:0]  TEMPO_FULL  = 2'd3;

  typedef enum logic [1:0] {
    FUNC_BYTE  = 2'd0,
    FUNC_READ  = 2'd1,
    FUNC_START = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    KIND_NOTE_OFF = 3'd0,
    KIND_NOTE_ON  = 3'd1,
    KIND_BEND     = 3'd2,
    KIND_TEMPO    = 3'd3,
    KIND_END      = 3'd4,
    KIND_DELTA    = 3'd5,
    KIND_READ     = 3'd6
  } kind_t;

  typedef enum logic [7:0] {
    PH_ENDED    = 8'b0000_0001,
    PH_DELTA    = 8'b0000_0010,
    PH_STATUS   = 8'b0000_0100,
    PH_DATA1    = 8'b0000_1000,
    PH_DATA2    = 8'b0001_0000,
    PH_METATYPE = 8'b0010_0000,
    PH_LEN      = 8'b0100_0000,
    PH_SKIP     = 8'b1000_0000
  } phase_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } ram_wr_t;

endpackage

/* hdl/midi_track_event_parser.sv */
// Channel  Dir  Payload (low bit up)                                   Handshake
// in_      in   tdata: data_byte[7:0] read_channel[11:8] read_note[18:12]  tvalid/tready
//               tuser: func[1:0]
// out_     out  tdata: channel note velocity bend tempo delta channel_used  tvalid/tready
//               tuser: kind[2:0]
//
// One transaction per cycle while the sweep is done and no result stalls: each item
// passes through the parse stage (input register -> parse logic -> result register),
// and the note table read is issued at accept so its data is ready in that stage.
// After reset the note table sweeps all 2048 entries to "off" (one entry per
// cycle); in_tready stays low during the sweep.
// A stalled result holds the parse stage only if that item also has a result;
// items without a result keep retiring behind a full output register.
module midi_track_event_parser
  import mtep_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // data_byte, read_channel, read_note
  input  logic [IN_TUSER_W-1:0]  in_tuser,   // func
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // channel[3:0] note[10:4] velocity[18:11]
                                             // bend[32:19] tempo[56:33] delta[88:57]
                                             // channel_used[89]
  output logic [OUT_TUSER_W-1:0] out_tuser   // kind
);

  // ---------------- input register ----------------
  logic              s1_valid_r;
  func_t             s1_func_r;
  logic [7:0]        s1_byte_r;
  logic [CH_W-1:0]   s1_rch_r;
  logic [NOTE_W-1:0] s1_rnote_r;
  logic              s1_go;
  logic              in_accept;
  logic              out_free;

  // ---------------- parser state ----------------
  phase_t      phase_r, phase_nxt;
  logic [7:0]  rs_r, rs_nxt;
  logic [7:0]  fd_r, fd_nxt;
  logic [31:0] vl_r, vl_nxt;
  logic [31:0] skip_r, skip_nxt;
  logic [7:0]  meta_r, meta_nxt;
  logic [23:0] tacc_r, tacc_nxt;
  logic [1:0]  tb_r, tb_nxt;
  logic [13:0] bend_r [CHANNEL_COUNT];
  logic        used_r [CHANNEL_COUNT];

  // ---------------- note table ----------------
  ram_wr_t           wr_raw;
  ram_wr_t           wr;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [7:0]        rd_data;
  logic              ram_busy;
  logic              fwd_hit_r;
  logic [7:0]        fwd_data_r;

  // ---------------- parse stage signals ----------------
  phase_t      eff_phase;
  logic [7:0]  eff_meta;
  logic [31:0] eff_vl;
  logic        do_proc;
  logic [7:0]  st;
  phase_t      st_phase;
  logic        st_clear;
  logic [31:0] vl_shift;
  logic [3:0]  hi;
  logic [CH_W-1:0]   ev_ch;
  logic [CH_W-1:0]   sel_ch;
  logic [NOTE_W-1:0] nt;
  logic [23:0] tempo_new;
  logic        bend_we;
  logic        used_set;

  logic              res_valid;
  kind_t             res_kind;
  logic [CH_W-1:0]   res_ch;
  logic [NOTE_W-1:0] res_note;
  logic [7:0]        res_vel;
  logic [13:0]       res_bend;
  logic [23:0]       res_tempo;
  logic [31:0]       res_delta;
  logic              res_used;

  // ---------------- result register ----------------
  logic              out_valid_r;
  kind_t             out_kind_r;
  logic [CH_W-1:0]   out_ch_r;
  logic [NOTE_W-1:0] out_note_r;
  logic [7:0]        out_vel_r;
  logic [13:0]       out_bend_r;
  logic [23:0]       out_tempo_r;
  logic [31:0]       out_delta_r;
  logic              out_used_r;

  // Handshake: the parse stage retires when it has no result or the result
  // register is free this cycle.
  assign out_free  = !out_valid_r || out_tready;
  assign s1_go     = s1_valid_r && (!res_valid || out_free);
  assign in_tready = !ram_busy && (!s1_valid_r || s1_go);
  assign in_accept = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_go) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_func_r  <= func_t'(in_tuser[1:0]);
      s1_byte_r  <= in_tdata[7:0];
      s1_rch_r   <= in_tdata[11:8];
      s1_rnote_r <= in_tdata[18:12];
    end
  end

  // Table read issued at accept; data lands with the item in the parse stage.
  assign rd_en   = in_accept && (func_t'(in_tuser[1:0]) == FUNC_READ);
  assign rd_addr = {in_tdata[11:8], in_tdata[18:12]};

  // The read can happen in the same cycle as a write from the item ahead, so
  // catch that write and bypass the stale read data.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      fwd_hit_r  <= wr.we && (wr.addr == rd_addr);
      fwd_data_r <= wr.data;
    end
  end

  mtep_note_ram u_note_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (wr),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .busy    (ram_busy)
  );

  assign wr.we   = wr_raw.we && s1_go;
  assign wr.addr = wr_raw.addr;
  assign wr.data = wr_raw.data;

  // Resolve a data byte seen in place of a status: either a delta byte (no
  // running status yet) or the first byte of an event under running status.
  assign st       = s1_byte_r[7] ? s1_byte_r : rs_r;
  assign st_clear = (st[7:4] == HI_SYSTEM) && (st != STATUS_META);

  always_comb begin
    if (st[7:4] != HI_SYSTEM) begin
      st_phase = PH_DATA1;
    end else if (st == STATUS_META) begin
      st_phase = PH_METATYPE;
    end else begin
      st_phase = PH_LEN;
    end
  end

  always_comb begin
    eff_phase = phase_r;
    eff_meta  = meta_r;
    eff_vl    = vl_r;
    do_proc   = 1'b1;
    if (phase_r == PH_STATUS) begin
      if (s1_byte_r[7]) begin
        do_proc = 1'b0;
      end else if (!rs_r[7]) begin
        eff_phase = PH_DELTA;
        eff_vl    = '0;
      end else begin
        eff_phase = st_phase;
        if (st_clear) begin
          eff_meta = '0;
          eff_vl   = '0;
        end
      end
    end
  end

  assign vl_shift  = {eff_vl[24:0], s1_byte_r[6:0]};
  assign hi        = rs_r[7:4];
  assign ev_ch     = rs_r[CH_W-1:0];
  assign nt        = fd_r[NOTE_W-1:0];
  assign tempo_new = {tacc_r[15:0], s1_byte_r};
  assign sel_ch    = (s1_func_r == FUNC_READ) ? s1_rch_r : ev_ch;

  // Parse one item against the current state.
  always_comb begin
    phase_nxt = phase_r;
    rs_nxt    = rs_r;
    fd_nxt    = fd_r;
    vl_nxt    = vl_r;
    skip_nxt  = skip_r;
    meta_nxt  = meta_r;
    tacc_nxt  = tacc_r;
    tb_nxt    = tb_r;
    wr_raw    = '0;
    bend_we   = 1'b0;
    used_set  = 1'b0;
    res_valid = 1'b0;
    res_kind  = KIND_DELTA;
    res_ch    = '0;
    res_note  = '0;
    res_vel   = '0;
    res_bend  = '0;
    res_tempo = '0;
    res_delta = '0;
    res_used  = 1'b0;

    unique case (s1_func_r)
      FUNC_READ: begin
        res_valid = 1'b1;
        res_kind  = KIND_READ;
        res_ch    = s1_rch_r;
        res_note  = s1_rnote_r;
        res_vel   = fwd_hit_r ? fwd_data_r : rd_data;
        res_bend  = bend_r[sel_ch];
        res_used  = used_r[sel_ch];
      end
      FUNC_START: begin
        rs_nxt    = '0;
        fd_nxt    = '0;
        skip_nxt  = '0;
        meta_nxt  = '0;
        tacc_nxt  = '0;
        tb_nxt    = '0;
        vl_nxt    = '0;
        phase_nxt = PH_DELTA;
      end
      FUNC_NONE: begin
      end
      FUNC_BYTE: begin
        if (!do_proc) begin
          // New status byte: latch it and open the event.
          rs_nxt    = s1_byte_r;
          phase_nxt = st_phase;
          if (st_clear) begin
            meta_nxt = '0;
            vl_nxt   = '0;
          end
        end else begin
          meta_nxt = eff_meta;
          vl_nxt   = eff_vl;
          unique case (eff_phase)
            PH_DELTA: begin
              phase_nxt = PH_DELTA;
              if (s1_byte_r[7]) begin
                vl_nxt = vl_shift;
              end else begin
                res_valid = 1'b1;
                res_kind  = KIND_DELTA;
                res_delta = vl_shift;
                vl_nxt    = '0;
                phase_nxt = PH_STATUS;
              end
            end
            PH_DATA1: begin
              fd_nxt = s1_byte_r;
              if (hi == HI_PROGRAM || hi == HI_PRESSURE) begin
                vl_nxt    = '0;
                phase_nxt = PH_DELTA;
              end else begin
                phase_nxt = PH_DATA2;
              end
            end
            PH_DATA2: begin
              vl_nxt    = '0;
              phase_nxt = PH_DELTA;
              if (hi == HI_NOTE_OFF) begin
                wr_raw    = '{we: 1'b1, addr: {ev_ch, nt}, data: VEL_OFF};
                res_valid = 1'b1;
                res_kind  = KIND_NOTE_OFF;
                res_ch    = ev_ch;
                res_note  = nt;
                res_vel   = VEL_OFF;
                res_used  = used_r[sel_ch];
              end else if (hi == HI_NOTE_ON) begin
                wr_raw    = '{we: 1'b1, addr: {ev_ch, nt}, data: s1_byte_r};
                used_set  = 1'b1;
                res_valid = 1'b1;
                res_kind  = KIND_NOTE_ON;
                res_ch    = ev_ch;
                res_note  = nt;
                res_vel   = s1_byte_r;
                res_used  = 1'b1;
              end else if (hi == HI_BEND) begin
                bend_we   = 1'b1;
                res_valid = 1'b1;
                res_kind  = KIND_BEND;
                res_ch    = ev_ch;
                res_bend  = {s1_byte_r[6:0], nt};
                res_used  = used_r[sel_ch];
              end
            end
            PH_METATYPE: begin
              meta_nxt  = s1_byte_r;
              vl_nxt    = '0;
              phase_nxt = PH_LEN;
            end
            PH_LEN: begin
              if (s1_byte_r[7]) begin
                vl_nxt    = vl_shift;
                phase_nxt = PH_LEN;
              end else begin
                skip_nxt = vl_shift;
                vl_nxt   = '0;
                tacc_nxt = '0;
                tb_nxt   = '0;
                if (eff_meta == META_EOT) begin
                  phase_nxt = PH_ENDED;
                  res_valid = 1'b1;
                  res_kind  = KIND_END;
                end else if (vl_shift != '0) begin
                  phase_nxt = PH_SKIP;
                end else begin
                  phase_nxt = PH_DELTA;
                end
              end
            end
            PH_SKIP: begin
              // Capture the first three tempo bytes, count off the rest.
              if (meta_r == META_TEMPO && tb_r != TEMPO_FULL) begin
                tacc_nxt = tempo_new;
                tb_nxt   = tb_r + 1'b1;
                if (tb_r == TEMPO_LAST) begin
                  res_valid = 1'b1;
                  res_kind  = KIND_TEMPO;
                  res_tempo = tempo_new;
                end
              end
              skip_nxt = skip_r - 1'b1;
              if (skip_r == 32'd1) begin
                vl_nxt    = '0;
                phase_nxt = PH_DELTA;
              end
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
      end
    endcase
  end

  // State advances as the item retires.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_ENDED;
      rs_r    <= '0;
      fd_r    <= '0;
      vl_r    <= '0;
      skip_r  <= '0;
      meta_r  <= '0;
      tacc_r  <= '0;
      tb_r    <= '0;
    end else if (s1_go) begin
      phase_r <= phase_nxt;
      rs_r    <= rs_nxt;
      fd_r    <= fd_nxt;
      vl_r    <= vl_nxt;
      skip_r  <= skip_nxt;
      meta_r  <= meta_nxt;
      tacc_r  <= tacc_nxt;
      tb_r    <= tb_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNEL_COUNT; i++) begin
        bend_r[i] <= BEND_CENTER;
        used_r[i] <= 1'b0;
      end
    end else if (s1_go) begin
      if (bend_we) begin
        bend_r[ev_ch] <= {s1_byte_r[6:0], nt};
      end
      if (used_set) begin
        used_r[ev_ch] <= 1'b1;
      end
    end
  end

  // Result register: load on retire with a result, drop once taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && res_valid) begin
      out_kind_r  <= res_kind;
      out_ch_r    <= res_ch;
      out_note_r  <= res_note;
      out_vel_r   <= res_vel;
      out_bend_r  <= res_bend;
      out_tempo_r <= res_tempo;
      out_delta_r <= res_delta;
      out_used_r  <= res_used;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tdata  = {6'd0, out_used_r, out_delta_r, out_tempo_r, out_bend_r,
                       out_vel_r, out_note_r, out_ch_r};

  // ---------------- assertions ----------------
  a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |-> !ram_busy)
    else $error("item accepted during note table sweep");

  a_start_to_delta: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_go && s1_func_r == FUNC_START) |=> (phase_r == PH_DELTA))
    else $error("start of track did not enter delta phase");

  a_end_to_ended: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_go && res_valid && res_kind == KIND_END) |=> (phase_r == PH_ENDED))
    else $error("end of track did not stop parsing");

  a_note_writes_table: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_go && res_valid && (res_kind == KIND_NOTE_ON || res_kind == KIND_NOTE_OFF))
      |-> (wr.we && wr.data == res_vel))
    else $error("note event without matching table write");

endmodule

/* hdl/mtep_note_ram.sv */
module mtep_note_ram
  import mtep_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  ram_wr_t           wr,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [7:0]        rd_data,
  output logic              busy
);

  logic [7:0]        mem [CHANNEL_COUNT*NOTE_COUNT];
  logic [7:0]        rd_data_r;
  logic [ADDR_W-1:0] clr_addr_r;
  logic              clr_busy_r;

  // Sweep every entry to "off" after reset, one per cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (clr_addr_r == {ADDR_W{1'b1}}) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      mem[clr_addr_r] <= VEL_OFF;
    end else if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;
  assign busy    = clr_busy_r;

endmodule
